/* sv/cdw_pkg.sv */
// ----------------------------------------------------------------------------
// cdw_pkg
// Shared types and constants for the 2D valid-window correlation core.
// ----------------------------------------------------------------------------
package cdw_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_KERNEL  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 38;
    localparam int XY_BITS     = 10;
    localparam int DIM_BITS    = 11;
    localparam int KS_BITS     = 4;
    localparam int KIDX_BITS   = 6;   // kernel entry index, MAX_KERNEL**2 entries
    localparam int KK_BITS     = 7;   // holds MAX_KERNEL**2 itself
    localparam int KPOS_BITS   = 3;   // position within one kernel row
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_KSIZE  = 2'd2
    } cfg_idx_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO     = 2'd1;
    localparam logic [1:0] STAT_KTOOBIG  = 2'd2;

    localparam logic MODE_COEF  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic                           mode;
        logic signed [SAMPLE_BITS-1:0]  sample_value;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]     conv_sum;
        logic [XY_BITS-1:0]             out_x;
        logic [XY_BITS-1:0]             out_y;
        logic [1:0]                     status;
        logic                           frame_last;
    } out_word_t;

endpackage

/* sv/conv2d_valid_window_core.sv */
// ----------------------------------------------------------------------------
// conv2d_valid_window_core
// Square-kernel 2D correlation over a pre-padded raster stream.
// ----------------------------------------------------------------------------
// Flow: coefficient words are stored and give no result. Error pixels load a
//   result via ST_RESULT. Windowed pixels step ST_MAC, ST_DRAIN, ST_RESULT.
// Throughput: one word per cycle (coef, non-emitting pixel) while no register
//   write is pending; the input is held off until an error result or an emitted sum is loaded,
//   the sums paced by one line-store read port feeding one MAC. A result still held on the output adds its stall.
// Reset: sync active-low; sizes 0, kernel 1, raster and coef counters 0.
//   Line store needs no clearing: every window tap was written earlier in the same frame.
module conv2d_valid_window_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  cdw_pkg::in_word_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output cdw_pkg::out_word_t                   m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cdw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [cdw_pkg::DIM_BITS-1:0]         cfg_data
);
    import cdw_pkg::*;

    localparam int LADDR_BITS = KPOS_BITS + DIM_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DRAIN, ST_RESULT} state_t;

    // Storage: coefficients and 8 rows of padded pixels, one row per row%8.
    logic signed [SAMPLE_BITS-1:0] kernel_mem [2**KIDX_BITS];
    logic signed [SAMPLE_BITS-1:0] line_mem   [2**LADDR_BITS];

    state_t                  state_reg;
    logic [DIM_BITS-1:0]     width_reg, height_reg;
    logic [KS_BITS-1:0]      ksize_reg;
    logic [DIM_BITS-1:0]     col_reg, row_reg;
    logic [KIDX_BITS-1:0]    coef_reg;
    logic [XY_BITS-1:0]      x_reg, y_reg;
    logic [KPOS_BITS-1:0]    ii_reg, jj_reg;
    logic [KIDX_BITS-1:0]    kidx_reg;
    logic [1:0]              drain_reg;
    logic                    rd_vld_reg;
    logic [1:0]              res_stat_reg;
    logic                    res_last_reg;
    logic                    m_valid_reg;
    out_word_t               m_data_reg;
    logic                    mac_clear;
    logic signed [SAMPLE_BITS-1:0] kdata_reg, ldata_reg;
    logic signed [SUM_BITS-1:0]    acc;

    // Effective (saturated) sizes.
    logic [KS_BITS-1:0]      keff;
    logic [DIM_BITS-1:0]     weff, heff, kdim, pw, ph;
    logic [KK_BITS-1:0]      kk;
    logic [1:0]              stat;
    logic                    in_acc, cfg_acc, win_rdy;
    logic                    rd_en;
    logic [KIDX_BITS-1:0]    kaddr;
    logic [LADDR_BITS-1:0]   laddr;
    logic [DIM_BITS-1:0]     lcol;
    logic [KPOS_BITS-1:0]    lrow;
    logic [DIM_BITS-1:0]     xcalc, ycalc;

    always_comb begin
        if (ksize_reg == '0) begin
            keff = KS_BITS'(1);
        end else if (ksize_reg > KS_BITS'(MAX_KERNEL)) begin
            keff = KS_BITS'(MAX_KERNEL);
        end else begin
            keff = ksize_reg;
        end
        weff = (width_reg  > DIM_BITS'(MAX_WIDTH))  ? DIM_BITS'(MAX_WIDTH)  : width_reg;
        heff = (height_reg > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_reg;
        kdim = {{(DIM_BITS-KS_BITS){1'b0}}, keff};
        kk   = {{(KK_BITS-KS_BITS){1'b0}}, keff} * {{(KK_BITS-KS_BITS){1'b0}}, keff};
        pw   = weff + kdim - DIM_BITS'(1);
        ph   = heff + kdim - DIM_BITS'(1);
        if (weff == '0 || heff == '0) begin
            stat = STAT_ZERO;
        end else if (kdim > weff || kdim > heff) begin
            stat = STAT_KTOOBIG;
        end else begin
            stat = STAT_OK;
        end
        win_rdy = (col_reg >= kdim - DIM_BITS'(1)) && (row_reg >= kdim - DIM_BITS'(1));
        xcalc   = col_reg + DIM_BITS'(1) - kdim;
        ycalc   = row_reg + DIM_BITS'(1) - kdim;
    end

    // Register writes only while idle; a pending write holds off the input.
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // Window tap address: row (y+jj) mod 8, column x+ii.
    assign rd_en = (state_reg == ST_MAC);
    assign kaddr = kidx_reg;
    assign lcol  = {1'b0, x_reg} + {{(DIM_BITS-KPOS_BITS){1'b0}}, ii_reg};
    assign lrow  = y_reg[KPOS_BITS-1:0] + jj_reg;
    assign laddr = {lrow, lcol};

    assign mac_clear = in_acc && s_data.mode == MODE_PIXEL && stat == STAT_OK && win_rdy;

    always_ff @(posedge aclk) begin
        if (in_acc && s_data.mode == MODE_COEF) begin
            kernel_mem[coef_reg] <= s_data.sample_value;
        end
        if (in_acc && s_data.mode == MODE_PIXEL && stat == STAT_OK) begin
            line_mem[{row_reg[KPOS_BITS-1:0], col_reg}] <= s_data.sample_value;
        end
        kdata_reg <= kernel_mem[kaddr];
        ldata_reg <= line_mem[laddr];
    end

    cdw_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (mac_clear),
        .in_vld  (rd_vld_reg),
        .pix     (ldata_reg),
        .coef    (kdata_reg),
        .acc     (acc)
    );

    // Control FSM with registered result word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            width_reg    <= '0;
            height_reg   <= '0;
            ksize_reg    <= KS_BITS'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            coef_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            // in ST_RESULT the load below decides m_valid_reg
            if (m_valid_reg && m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_acc && s_data.mode == MODE_COEF) begin
                        if ({1'b0, coef_reg} + KK_BITS'(1) >= kk) begin
                            coef_reg <= '0;
                        end else begin
                            coef_reg <= coef_reg + KIDX_BITS'(1);
                        end
                    end else if (in_acc) begin
                        if (stat != STAT_OK) begin
                            res_stat_reg <= stat;
                            res_last_reg <= 1'b0;
                            x_reg        <= '0;
                            y_reg        <= '0;
                            state_reg    <= ST_RESULT;
                        end else begin
                            if (win_rdy) begin
                                x_reg        <= xcalc[XY_BITS-1:0];
                                y_reg        <= ycalc[XY_BITS-1:0];
                                res_stat_reg <= STAT_OK;
                                res_last_reg <= (xcalc == weff - DIM_BITS'(1))
                                             && (ycalc == heff - DIM_BITS'(1));
                                ii_reg       <= '0;
                                jj_reg       <= '0;
                                kidx_reg     <= '0;
                                state_reg    <= ST_MAC;
                            end
                            // advance raster position over padded frame
                            if (col_reg + DIM_BITS'(1) >= pw) begin
                                col_reg <= '0;
                                if (row_reg + DIM_BITS'(1) >= ph) begin
                                    row_reg <= '0;
                                end else begin
                                    row_reg <= row_reg + DIM_BITS'(1);
                                end
                            end else begin
                                col_reg <= col_reg + DIM_BITS'(1);
                            end
                        end
                    end
                end
                ST_MAC: begin
                    kidx_reg <= kidx_reg + KIDX_BITS'(1);
                    if ({1'b0, ii_reg} == keff - KS_BITS'(1)) begin
                        ii_reg <= '0;
                        jj_reg <= jj_reg + KPOS_BITS'(1);
                        if ({1'b0, jj_reg} == keff - KS_BITS'(1)) begin
                            drain_reg <= 2'd2;
                            state_reg <= ST_DRAIN;
                        end
                    end else begin
                        ii_reg <= ii_reg + KPOS_BITS'(1);
                    end
                end
                ST_DRAIN: begin
                    // wait out read, product and accumulate stages
                    if (drain_reg == '0) begin
                        state_reg <= ST_RESULT;
                    end else begin
                        drain_reg <= drain_reg - 2'd1;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.conv_sum   <= (res_stat_reg == STAT_OK) ? acc : '0;
                        m_data_reg.out_x      <= x_reg;
                        m_data_reg.out_y      <= y_reg;
                        m_data_reg.status     <= res_stat_reg;
                        m_data_reg.frame_last <= res_last_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // any register write restarts the frame
            if (cfg_acc) begin
                case (cfg_index)
                    CFG_WIDTH: begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    CFG_HEIGHT: begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    CFG_KSIZE: begin
                        ksize_reg <= cfg_data[KS_BITS-1:0];
                        coef_reg  <= '0;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/cdw_mac.sv */
// ----------------------------------------------------------------------------
// cdw_mac
// Two-stage multiply-accumulate: registered product, then 38-bit sum.
// ----------------------------------------------------------------------------
module cdw_mac (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    clear,
    input  logic                                    in_vld,
    input  logic signed [cdw_pkg::SAMPLE_BITS-1:0]  pix,
    input  logic signed [cdw_pkg::SAMPLE_BITS-1:0]  coef,
    output logic signed [cdw_pkg::SUM_BITS-1:0]     acc
);
    import cdw_pkg::*;

    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic                            prod_vld_reg;
    logic signed [SUM_BITS-1:0]      acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= in_vld;
            if (clear) begin
                acc_reg <= '0;
            end else if (prod_vld_reg) begin
                acc_reg <= acc_reg + SUM_BITS'(prod_reg);
            end
        end
        prod_reg <= pix * coef;
    end

    assign acc = acc_reg;

endmodule
